// ===== src/fqp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package fqp_pkg;

    // Character codes that steer the parser.
    localparam logic [7:0] CH_AT      = 8'h40;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_NL      = 8'h0A;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] CASE_DELTA = 8'h20;

    typedef enum logic [2:0] {
        PH_EXPECT_AT   = 3'd0,
        PH_ID          = 3'd1,
        PH_SKIP_HDR    = 3'd2,
        PH_SEQ         = 3'd3,
        PH_EXPECT_PLUS = 3'd4,
        PH_SKIP_PLUS   = 3'd5,
        PH_QUAL        = 3'd6,
        PH_STOPPED     = 3'd7
    } t_phase;

    typedef enum logic [2:0] {
        K_ID     = 3'd0,
        K_SEQ    = 3'd1,
        K_QUAL   = 3'd2,
        K_DONE   = 3'd3,
        K_END    = 3'd4,
        K_BADHDR = 3'd5,
        K_NOPLUS = 3'd6
    } t_kind;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       end_of_input;
    } t_in_word;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] char_value;
        logic [9:0] position;
    } t_out_word;

    function automatic logic is_ws(input logic [7:0] b);
        return (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
    endfunction

endpackage

`default_nettype wire

// ===== src/fqp_parse.sv =====
`timescale 1ns / 1ps
`default_nettype none

module fqp_parse
    import fqp_pkg::*;
#(
    parameter int ID_MAX  = 255,
    parameter int SEQ_MAX = 1023
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_accept,
    input  wire t_in_word  i_data,
    output logic           o_res_valid,
    output t_out_word      o_res
);

    localparam int MAX_CNT = (ID_MAX > SEQ_MAX) ? ID_MAX : SEQ_MAX;
    localparam int CW      = $clog2(MAX_CNT + 1);
    localparam logic [CW-1:0] ID_LIM  = CW'(ID_MAX);
    localparam logic [CW-1:0] SEQ_LIM = CW'(SEQ_MAX);

    t_phase        r_phase, n_phase;
    logic [CW-1:0] r_count, n_count;

    logic [7:0] b;
    logic       ws;
    logic [7:0] upper;

    assign b     = i_data.byte_value;
    assign ws    = is_ws(b);
    assign upper = ((b >= CH_LOWER_A) && (b <= CH_LOWER_Z)) ? (b - CASE_DELTA) : b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_EXPECT_AT;
            r_count <= '0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_count <= n_count;
        end
    end

    always_comb begin
        n_phase          = r_phase;
        n_count          = r_count;
        o_res_valid      = 1'b0;
        o_res.kind       = K_END;
        o_res.char_value = '0;
        o_res.position   = '0;
        if (r_phase != PH_STOPPED && i_data.end_of_input) begin
            n_phase     = PH_STOPPED;
            o_res_valid = 1'b1;
        end else begin
            unique case (r_phase)
                PH_EXPECT_AT: begin
                    if (b == CH_AT) begin
                        n_phase = PH_ID;
                        n_count = '0;
                    end else begin
                        n_phase     = PH_STOPPED;
                        o_res_valid = 1'b1;
                        o_res.kind  = K_BADHDR;
                    end
                end
                PH_ID: begin
                    if (ws || r_count >= ID_LIM) begin
                        n_phase = (b == CH_NL) ? PH_SEQ : PH_SKIP_HDR;
                        n_count = '0;
                    end else begin
                        n_count          = r_count + 1'b1;
                        o_res_valid      = 1'b1;
                        o_res.kind       = K_ID;
                        o_res.char_value = b;
                        o_res.position   = 10'(r_count);
                    end
                end
                PH_SKIP_HDR: begin
                    if (b == CH_NL) begin
                        n_phase = PH_SEQ;
                        n_count = '0;
                    end
                end
                PH_SEQ: begin
                    if (b == CH_NL) begin
                        n_phase = PH_EXPECT_PLUS;
                    end else if (!ws && r_count < SEQ_LIM) begin
                        n_count          = r_count + 1'b1;
                        o_res_valid      = 1'b1;
                        o_res.kind       = K_SEQ;
                        o_res.char_value = upper;
                        o_res.position   = 10'(r_count);
                    end
                end
                PH_EXPECT_PLUS: begin
                    if (b == CH_PLUS) begin
                        n_phase = PH_SKIP_PLUS;
                    end else begin
                        // Resynchronize: the next byte must open a new record.
                        n_phase     = PH_EXPECT_AT;
                        n_count     = '0;
                        o_res_valid = 1'b1;
                        o_res.kind  = K_NOPLUS;
                    end
                end
                PH_SKIP_PLUS: begin
                    if (b == CH_NL) begin
                        n_phase = PH_QUAL;
                        n_count = '0;
                    end
                end
                PH_QUAL: begin
                    if (b == CH_NL) begin
                        n_phase        = PH_EXPECT_AT;
                        n_count        = '0;
                        o_res_valid    = 1'b1;
                        o_res.kind     = K_DONE;
                        o_res.position = 10'(r_count);
                    end else if (!ws && r_count < SEQ_LIM) begin
                        n_count          = r_count + 1'b1;
                        o_res_valid      = 1'b1;
                        o_res.kind       = K_QUAL;
                        o_res.char_value = b;
                        o_res.position   = 10'(r_count);
                    end
                end
                PH_STOPPED: begin
                    n_phase = PH_STOPPED;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== src/fqp_out_buf.sv =====
`timescale 1ns / 1ps
`default_nettype none

module fqp_out_buf
    import fqp_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_push,
    input  wire t_out_word i_word,
    output logic           o_full,
    output logic           o_valid,
    input  wire logic      i_stall,
    output t_out_word      o_word
);

    logic      r_out_valid;
    logic      r_skid_valid;
    t_out_word r_out;
    t_out_word r_skid;

    // The skid register catches a word that arrives while the output is held,
    // so the upstream stall comes from a register only.
    assign o_full  = r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_word  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || !i_stall) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= i_push;
            end
        end else if (i_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || !i_stall) begin
            r_out <= r_skid_valid ? r_skid : i_word;
        end else if (i_push) begin
            r_skid <= i_word;
        end
    end

endmodule

`default_nettype wire

// ===== src/fastq_record_parser.sv =====
// FASTQ record parser: one text byte per cycle in (while not stalled), at most one word out per byte.
// A result word is held in the output register, or in the skid register while the output is stalled.
// Throughput: one byte per cycle while the input is not stalled, set by the parse state update;
// a word that meets an output stall waits in a second register, and input stalls while it waits.
// Reset (synchronous, active low) returns the parser to waiting for '@' with a
// zero count and empties the output buffer; a stopped parser leaves only by reset.
`timescale 1ns / 1ps
`default_nettype none

module fastq_record_parser
    import fqp_pkg::*;
#(
    parameter int ID_MAX  = 255,
    parameter int SEQ_MAX = 1023
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_valid,
    output logic           o_stall,
    input  wire t_in_word  i_data,
    output logic           o_valid,
    input  wire logic      i_stall,
    output t_out_word      o_data
);

    logic      accept;
    logic      res_valid;
    t_out_word res;
    logic      buf_full;

    assign o_stall = buf_full;
    assign accept  = i_valid && !buf_full;

    fqp_parse #(
        .ID_MAX  (ID_MAX),
        .SEQ_MAX (SEQ_MAX)
    ) u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_data      (i_data),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    fqp_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept && res_valid),
        .i_word  (res),
        .o_full  (buf_full),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_word  (o_data)
    );

endmodule

`default_nettype wire
